// ===== hw/rtl/hcx_pkg.sv =====
// Shared types and constants for the Hack CPU execute unit.
package hcx_pkg;

   localparam int unsigned WORD_W = 16;

   // Instruction field positions (standard Hack encoding).
   localparam int unsigned BIT_COMPUTE = 15;
   localparam int unsigned BIT_A_SEL   = 12;
   localparam int unsigned BIT_ZX      = 11;
   localparam int unsigned BIT_NX      = 10;
   localparam int unsigned BIT_ZY      = 9;
   localparam int unsigned BIT_NY      = 8;
   localparam int unsigned BIT_F       = 7;
   localparam int unsigned BIT_NO      = 6;
   localparam int unsigned BIT_DEST_A  = 5;
   localparam int unsigned BIT_DEST_D  = 4;
   localparam int unsigned BIT_DEST_M  = 3;
   localparam int unsigned BIT_JLT     = 2;
   localparam int unsigned BIT_JEQ     = 1;
   localparam int unsigned BIT_JGT     = 0;

   typedef logic [WORD_W-1:0] word_type;

   // Control bits that steer the ALU and the jump decision.
   typedef struct packed {
      logic zx;
      logic nx;
      logic zy;
      logic ny;
      logic f;
      logic no;
      logic jlt;
      logic jeq;
      logic jgt;
   } alu_ctl_type;

endpackage

// ===== hw/rtl/hcx_if.sv =====
// Handshake channel interfaces for the instruction and result streams.
interface hcx_req_if;
   logic                 valid;
   logic                 ready;
   hcx_pkg::word_type    instruction;

   modport source (output valid, output instruction, input ready);
   modport sink   (input valid, input instruction, output ready);
endinterface

interface hcx_rsp_if;
   logic                 valid;
   logic                 ready;
   logic [15:0]          next_pc;
   logic signed [15:0]   a_value;
   logic signed [15:0]   d_value;
   logic signed [15:0]   alu_result;
   logic                 jump_taken;

   modport source (output valid, output next_pc, output a_value, output d_value,
                   output alu_result, output jump_taken, input ready);
   modport sink   (input valid, input next_pc, input a_value, input d_value,
                   input alu_result, input jump_taken, output ready);
endinterface

// ===== hw/rtl/hcx_alu.sv =====
// Hack ALU with flag generation and jump condition.
module hcx_alu (
   input  hcx_pkg::alu_ctl_type ctl,
   input  hcx_pkg::word_type    x_op,
   input  hcx_pkg::word_type    y_op,
   output hcx_pkg::word_type    result,
   output logic                 taken
);

   hcx_pkg::word_type x_m;
   hcx_pkg::word_type y_m;
   hcx_pkg::word_type r_m;
   logic              zero_flag;
   logic              sign_flag;

   always_comb begin
      x_m = ctl.zx ? '0 : x_op;
      x_m = ctl.nx ? ~x_m : x_m;
      y_m = ctl.zy ? '0 : y_op;
      y_m = ctl.ny ? ~y_m : y_m;
      r_m = ctl.f ? (x_m + y_m) : (x_m & y_m);
      r_m = ctl.no ? ~r_m : r_m;
   end

   assign result    = r_m;
   assign zero_flag = (r_m == '0);
   assign sign_flag = r_m[hcx_pkg::WORD_W-1];
   assign taken     = (sign_flag && ctl.jlt) || (zero_flag && ctl.jeq) ||
                      (!sign_flag && !zero_flag && ctl.jgt);

endmodule

// ===== hw/rtl/hcx_ram.sv =====
// Data RAM with registered read, write bypass and a clearing sweep after reset.
module hcx_ram #(
   parameter int unsigned MEM_DEPTH = 32768,
   localparam int unsigned AW = $clog2(MEM_DEPTH)
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              rd_en,
   input  logic [AW-1:0]     rd_addr,
   output hcx_pkg::word_type rd_data,
   input  logic              wr_en,
   input  logic [AW-1:0]     wr_addr,
   input  hcx_pkg::word_type wr_data,
   output logic              busy
);

   localparam logic [AW-1:0] LAST_IDX = AW'(MEM_DEPTH - 1);

   hcx_pkg::word_type mem [MEM_DEPTH];

   logic              busy_ff, busy_in;
   logic [AW-1:0]     clr_ptr_ff, clr_ptr_in;
   hcx_pkg::word_type mem_q_ff;
   logic              byp_hit_ff, byp_hit_in;
   hcx_pkg::word_type byp_data_ff;

   logic              we;
   logic [AW-1:0]     waddr;
   hcx_pkg::word_type wdata;

   // The sweep owns the write port until every entry has been zeroed.
   assign we    = busy_ff || wr_en;
   assign waddr = busy_ff ? clr_ptr_ff : wr_addr;
   assign wdata = busy_ff ? '0 : wr_data;

   assign busy_in    = busy_ff && (clr_ptr_ff != LAST_IDX);
   assign clr_ptr_in = clr_ptr_ff + AW'(1);
   assign byp_hit_in = we && (waddr == rd_addr);

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff    <= 1'b1;
         clr_ptr_ff <= '0;
      end else begin
         busy_ff    <= busy_in;
         clr_ptr_ff <= clr_ptr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         mem_q_ff    <= mem[rd_addr];
         byp_hit_ff  <= byp_hit_in;
         byp_data_ff <= wdata;
      end
   end

   assign rd_data = byp_hit_ff ? byp_data_ff : mem_q_ff;
   assign busy    = busy_ff;

endmodule

// ===== hw/rtl/hack_cpu_execute_unit.sv =====
// Hack CPU execute unit: runs one Hack instruction per transfer and reports the new state.
//
// Each accepted instruction produces exactly one result transfer carrying the next PC,
// the A and D registers after the instruction, the ALU output and the jump flag. The
// unit is a two-stage pipeline around a single-port-write, registered-read data RAM:
// the accept cycle issues the RAM read at A, and the execute stage then runs the ALU,
// updates A, D and PC, writes RAM[A] back and loads the result register. Instructions
// therefore stream at one per cycle when the output keeps up. The exception is a compute
// instruction that writes A: the following instruction needs the new A as its RAM
// address, so it is held off until that instruction retires. A write to RAM in
// the execute cycle that hits the address being read for the next instruction is
// forwarded, so back-to-back read-modify-write sequences see the fresh value. After
// reset the RAM is cleared by a sweep over all MEM_DEPTH entries, one entry per cycle,
// during which no instruction is taken. The RAM is addressed by A modulo MEM_DEPTH. A
// full result register stalls the input only while it keeps a valid execute stage
// from retiring; the input also stalls during the sweep and behind a compute that writes A.
module hack_cpu_execute_unit #(
   parameter int unsigned MEM_DEPTH = 32768
) (
   input  logic      clock,
   input  logic      reset,
   hcx_req_if.sink   req_bus,
   hcx_rsp_if.source rsp_bus
);

   localparam int unsigned AW       = $clog2(MEM_DEPTH);
   localparam bit          IS_POW2  = (MEM_DEPTH & (MEM_DEPTH - 1)) == 0;
   localparam int unsigned QMAX     = 65535 / MEM_DEPTH;
   localparam int unsigned QB       = $clog2(QMAX + 1);

   // Architectural registers.
   hcx_pkg::word_type a_ff, a_in;
   hcx_pkg::word_type d_ff, d_in;
   hcx_pkg::word_type pc_ff, pc_in;

   // Execute stage.
   logic              ex_valid_ff, ex_valid_in;
   hcx_pkg::word_type ex_instr_ff;
   logic [AW-1:0]     ex_idx_ff;

   // Result register.
   logic              rsp_valid_ff, rsp_valid_in;
   hcx_pkg::word_type rsp_pc_ff, rsp_a_ff, rsp_d_ff, rsp_alu_ff;
   logic              rsp_jump_ff;

   logic              ram_busy;
   hcx_pkg::word_type ram_rd_data;
   logic              out_free;
   logic              ex_fire;
   logic              ex_is_c;
   logic              a_hazard;
   logic              req_ready;
   logic              accept;
   hcx_pkg::word_type rd_word;
   logic [AW-1:0]     rd_idx;
   hcx_pkg::word_type y_op;
   hcx_pkg::word_type alu_res;
   logic              alu_taken;
   logic              jump_now;
   hcx_pkg::alu_ctl_type alu_ctl;

   // The result register can take a new item when empty or when its item leaves now.
   assign out_free = !rsp_valid_ff || rsp_bus.ready;
   assign ex_fire  = ex_valid_ff && out_free;
   assign ex_is_c  = ex_instr_ff[hcx_pkg::BIT_COMPUTE];

   // A compute that writes A leaves the next RAM address unknown until it retires.
   assign a_hazard  = ex_valid_ff && ex_is_c && ex_instr_ff[hcx_pkg::BIT_DEST_A];
   assign req_ready = !ram_busy && (!ex_valid_ff || ex_fire) && !a_hazard;
   assign accept    = req_bus.valid && req_ready;

   // The A value the next instruction will see: a load-A retiring now supplies it.
   assign rd_word = (ex_valid_ff && !ex_is_c) ? ex_instr_ff : a_ff;

   generate
      if (IS_POW2) begin : g_idx_mask
         assign rd_idx = rd_word[AW-1:0];
      end else begin : g_idx_reduce
         // Reduction by the constant depth, one shifted multiple per step.
         logic [15:0] rem;
         always_comb begin
            rem = rd_word;
            for (int k = QB - 1; k >= 0; k--) begin
               if (32'(rem) >= (32'(MEM_DEPTH) << k)) begin
                  rem = rem - 16'(32'(MEM_DEPTH) << k);
               end
            end
         end
         assign rd_idx = AW'(rem);
      end
   endgenerate

   hcx_ram #(
      .MEM_DEPTH (MEM_DEPTH)
   ) u_ram (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (accept),
      .rd_addr (rd_idx),
      .rd_data (ram_rd_data),
      .wr_en   (ex_fire && ex_is_c && ex_instr_ff[hcx_pkg::BIT_DEST_M]),
      .wr_addr (ex_idx_ff),
      .wr_data (alu_res),
      .busy    (ram_busy)
   );

   always_comb begin
      alu_ctl.zx  = ex_instr_ff[hcx_pkg::BIT_ZX];
      alu_ctl.nx  = ex_instr_ff[hcx_pkg::BIT_NX];
      alu_ctl.zy  = ex_instr_ff[hcx_pkg::BIT_ZY];
      alu_ctl.ny  = ex_instr_ff[hcx_pkg::BIT_NY];
      alu_ctl.f   = ex_instr_ff[hcx_pkg::BIT_F];
      alu_ctl.no  = ex_instr_ff[hcx_pkg::BIT_NO];
      alu_ctl.jlt = ex_instr_ff[hcx_pkg::BIT_JLT];
      alu_ctl.jeq = ex_instr_ff[hcx_pkg::BIT_JEQ];
      alu_ctl.jgt = ex_instr_ff[hcx_pkg::BIT_JGT];
   end

   assign y_op = ex_instr_ff[hcx_pkg::BIT_A_SEL] ? ram_rd_data : a_ff;

   hcx_alu u_alu (
      .ctl    (alu_ctl),
      .x_op   (d_ff),
      .y_op   (y_op),
      .result (alu_res),
      .taken  (alu_taken)
   );

   assign jump_now = ex_is_c && alu_taken;

   // Next architectural state; the jump target is A as it stood before this instruction.
   always_comb begin
      a_in  = a_ff;
      d_in  = d_ff;
      pc_in = jump_now ? a_ff : (pc_ff + 16'd1);
      if (!ex_is_c) begin
         a_in = ex_instr_ff;
      end else begin
         if (ex_instr_ff[hcx_pkg::BIT_DEST_A]) begin
            a_in = alu_res;
         end
         if (ex_instr_ff[hcx_pkg::BIT_DEST_D]) begin
            d_in = alu_res;
         end
      end
   end

   assign ex_valid_in  = accept ? 1'b1 : (ex_fire ? 1'b0 : ex_valid_ff);
   assign rsp_valid_in = ex_fire ? 1'b1 : (rsp_bus.ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         a_ff         <= '0;
         d_ff         <= '0;
         pc_ff        <= '0;
         ex_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         ex_valid_ff  <= ex_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (ex_fire) begin
            a_ff  <= a_in;
            d_ff  <= d_in;
            pc_ff <= pc_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         ex_instr_ff <= req_bus.instruction;
         ex_idx_ff   <= rd_idx;
      end
      if (ex_fire) begin
         rsp_pc_ff   <= pc_in;
         rsp_a_ff    <= a_in;
         rsp_d_ff    <= d_in;
         rsp_alu_ff  <= ex_is_c ? alu_res : '0;
         rsp_jump_ff <= jump_now;
      end
   end

   assign req_bus.ready      = req_ready;
   assign rsp_bus.valid      = rsp_valid_ff;
   assign rsp_bus.next_pc    = rsp_pc_ff;
   assign rsp_bus.a_value    = $signed(rsp_a_ff);
   assign rsp_bus.d_value    = $signed(rsp_d_ff);
   assign rsp_bus.alu_result = $signed(rsp_alu_ff);
   assign rsp_bus.jump_taken = rsp_jump_ff;

endmodule
